// ===== rtl/wifi_mac_header_parser_unit_assert.svh =====
// assertion macros shared by the parser modules
`ifndef WIFI_MAC_HEADER_PARSER_UNIT_ASSERT_SVH
`define WIFI_MAC_HEADER_PARSER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// cond holds -> expr holds in the same cycle
`define WMHP_ASSERT_IMPLY(label, clock, resetn, cond, expr) \
    label: assert property (@(posedge clock) disable iff (!resetn) (cond) |-> (expr)) \
        else $error("wmhp assertion failed");

// cond holds -> expr holds in the next cycle
`define WMHP_ASSERT_NEXT(label, clock, resetn, cond, expr) \
    label: assert property (@(posedge clock) disable iff (!resetn) (cond) |=> (expr)) \
        else $error("wmhp assertion failed");

`else

`define WMHP_ASSERT_IMPLY(label, clock, resetn, cond, expr)
`define WMHP_ASSERT_NEXT(label, clock, resetn, cond, expr)

`endif

`endif

// ===== rtl/wmhp_pkg.sv =====
`timescale 1ns / 1ps

package wmhp_pkg;

    // header store: two banks of one maximum header each
    localparam int STORE_DEPTH = 36;
    localparam int NUM_BANKS   = 2;
    localparam int RAM_DEPTH   = NUM_BANKS * STORE_DEPTH;
    localparam int RAM_AW      = $clog2(RAM_DEPTH);
    localparam int BYTE_W      = 8;

    localparam int CNT_W       = 6;
    localparam int KIND_W      = 4;
    localparam int NUM_KINDS   = 11;
    localparam int OFF_W       = 6;
    localparam int VALUE_W     = 48;
    localparam int IDX_W       = 3;
    localparam int STATUS_W    = 3;
    localparam int FTYPE_W     = 2;
    localparam int SUB_W       = 4;
    localparam int HLEN_W      = 6;

    localparam int QUEUE_DEPTH = 2;

    // record kinds
    localparam logic [KIND_W-1:0] KIND_FC          = 4'd0;
    localparam logic [KIND_W-1:0] KIND_DURATION    = 4'd1;
    localparam logic [KIND_W-1:0] KIND_RECEIVER    = 4'd2;
    localparam logic [KIND_W-1:0] KIND_TRANSMITTER = 4'd3;
    localparam logic [KIND_W-1:0] KIND_DEST        = 4'd4;
    localparam logic [KIND_W-1:0] KIND_SOURCE      = 4'd5;
    localparam logic [KIND_W-1:0] KIND_BSSID       = 4'd6;
    localparam logic [KIND_W-1:0] KIND_SEQUENCE    = 4'd7;
    localparam logic [KIND_W-1:0] KIND_QOS         = 4'd8;
    localparam logic [KIND_W-1:0] KIND_HT          = 4'd9;
    localparam logic [KIND_W-1:0] KIND_SUMMARY     = 4'd10;

    // parse status codes
    localparam logic [STATUS_W-1:0] ST_PARSED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_SHORT   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_VERSION = 3'd2;
    localparam logic [STATUS_W-1:0] ST_LAYOUT  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FLAGS   = 3'd4;

    // frame types
    localparam logic [FTYPE_W-1:0] TYPE_MGMT    = 2'd0;
    localparam logic [FTYPE_W-1:0] TYPE_CTRL    = 2'd1;
    localparam logic [FTYPE_W-1:0] TYPE_DATA    = 2'd2;
    localparam logic [FTYPE_W-1:0] TYPE_UNKNOWN = 2'd3;

    // one classified run, handed from front to back
    typedef struct packed {
        logic                                bank;
        logic [NUM_KINDS-1:0]                rec_en;
        logic [NUM_KINDS-1:0][OFF_W-1:0]     rec_off;
        logic [STATUS_W-1:0]                 status;
        logic [FTYPE_W-1:0]                  ftype;
        logic [SUB_W-1:0]                    subtype;
        logic [HLEN_W-1:0]                   hdr_len;
    } run_desc_t;

    // back tells front a bank has been read out
    typedef struct packed {
        logic valid;
        logic bank;
    } bank_done_t;

    typedef struct packed {
        logic              en;
        logic [RAM_AW-1:0] addr;
        logic [BYTE_W-1:0] data;
    } ram_wr_t;

    typedef struct packed {
        logic              en;
        logic [RAM_AW-1:0] addr;
    } ram_rd_t;

    // bytes read per record (summary carries no header bytes)
    function automatic logic [IDX_W-1:0] kind_len(input logic [KIND_W-1:0] kind);
        logic [IDX_W-1:0] len;
        unique case (kind)
            KIND_FC, KIND_DURATION, KIND_SEQUENCE, KIND_QOS: len = 3'd2;
            KIND_RECEIVER, KIND_TRANSMITTER, KIND_DEST,
            KIND_SOURCE, KIND_BSSID:                         len = 3'd6;
            KIND_HT:                                         len = 3'd4;
            default:                                         len = 3'd1;
        endcase
        return len;
    endfunction

endpackage

// ===== rtl/wmhp_ram.sv =====
`timescale 1ns / 1ps

module wmhp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/wmhp_front.sv =====
`timescale 1ns / 1ps
`include "wifi_mac_header_parser_unit_assert.svh"

module wmhp_front
    import wmhp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_valid,
    output logic              byte_stall,
    input  logic [BYTE_W-1:0] byte_value,
    input  logic              last_byte,
    input  bank_done_t        bank_done,
    output ram_wr_t           ram_wr,
    output logic              push_valid,
    output run_desc_t         push_desc
);

    // byte offsets within the header
    localparam logic [OFF_W-1:0] OFF_DURATION = 6'd2;
    localparam logic [OFF_W-1:0] OFF_ADDR1    = 6'd4;
    localparam logic [OFF_W-1:0] OFF_ADDR2    = 6'd10;
    localparam logic [OFF_W-1:0] OFF_CTRL_HT  = 6'd12;
    localparam logic [OFF_W-1:0] OFF_ADDR3    = 6'd16;
    localparam logic [OFF_W-1:0] OFF_SEQ      = 6'd22;
    localparam logic [OFF_W-1:0] OFF_ADDR4    = 6'd24;

    localparam logic [HLEN_W-1:0] HLEN_CTRL_SHORT = 6'd10;
    localparam logic [HLEN_W-1:0] HLEN_CTRL_LONG  = 6'd16;
    localparam logic [HLEN_W-1:0] HLEN_BASE       = 6'd24;
    localparam logic [HLEN_W-1:0] HLEN_ADDR4      = 6'd6;
    localparam logic [HLEN_W-1:0] HLEN_QOS        = 6'd2;
    localparam logic [HLEN_W-1:0] HLEN_HT         = 6'd4;

    localparam logic [CNT_W-1:0] N_FC  = 6'd2;
    localparam logic [CNT_W-1:0] N_DUR = 6'd4;

    // subtype codes
    localparam logic [SUB_W-1:0] SUB_MGMT_RSVD_LO  = 4'd7;
    localparam logic [SUB_W-1:0] SUB_MGMT_RSVD_HI  = 4'd15;
    localparam logic [SUB_W-1:0] SUB_CTRL_NDPA     = 4'd5;
    localparam logic [SUB_W-1:0] SUB_CTRL_WRAPPER  = 4'd7;
    localparam logic [SUB_W-1:0] SUB_CTRL_PS_POLL  = 4'd10;
    localparam logic [SUB_W-1:0] SUB_CTRL_CTS      = 4'd12;
    localparam logic [SUB_W-1:0] SUB_CTRL_ACK      = 4'd13;
    localparam logic [SUB_W-1:0] SUB_CTRL_CF_END   = 4'd14;
    localparam logic [SUB_W-1:0] SUB_CTRL_CF_END_A = 4'd15;
    localparam logic [SUB_W-1:0] SUB_DATA_RSVD     = 4'd13;

    localparam int FC_TO_DS_BIT   = 8;
    localparam int FC_FROM_DS_BIT = 9;
    localparam int FC_ORDER_BIT   = 15;
    localparam int FC_QOS_SUB_BIT = 3;

    logic [CNT_W-1:0] count_reg, count_next;
    logic             discard_reg, discard_next;
    logic             wbank_reg, wbank_next;
    logic [1:0]       busy_reg, busy_next;
    logic [15:0]      fc_reg;

    logic              accept;
    logic [CNT_W-1:0]  n_bytes;
    logic [15:0]       fc_now;
    logic              have_fc, ver_bad, type_ok, known, to_ds, from_ds, order;
    logic [FTYPE_W-1:0] ftype_raw;
    logic [SUB_W-1:0]  sub_raw;
    logic [HLEN_W-1:0] hlen;
    logic [OFF_W-1:0]  qos_off, ht_off;
    logic [STATUS_W-1:0] status;
    logic              more_dur, dur_ok, emit;
    logic [NUM_KINDS-1:0]            rec_en;
    logic [NUM_KINDS-1:0][OFF_W-1:0] rec_off;

    assign byte_stall = !discard_reg && busy_reg[wbank_reg];
    assign accept     = byte_valid && !byte_stall;
    assign n_bytes    = count_reg + CNT_W'(1);

    // frame control as it stands with this byte included
    assign fc_now = {(count_reg == CNT_W'(1)) ? byte_value : fc_reg[15:8],
                     (count_reg == '0)        ? byte_value : fc_reg[7:0]};

    always_comb
    begin
        have_fc   = n_bytes >= N_FC;
        ver_bad   = fc_now[1:0] != 2'b00;
        ftype_raw = fc_now[3:2];
        sub_raw   = fc_now[7:4];
        to_ds     = fc_now[FC_TO_DS_BIT];
        from_ds   = fc_now[FC_FROM_DS_BIT];
        order     = fc_now[FC_ORDER_BIT];
        type_ok   = have_fc && !ver_bad && (ftype_raw != TYPE_UNKNOWN);

        unique case (ftype_raw)
            TYPE_MGMT:    known = (sub_raw != SUB_MGMT_RSVD_LO) && (sub_raw != SUB_MGMT_RSVD_HI);
            TYPE_CTRL:    known = (sub_raw == SUB_CTRL_NDPA) || (sub_raw >= SUB_CTRL_WRAPPER);
            TYPE_DATA:    known = sub_raw != SUB_DATA_RSVD;
            TYPE_UNKNOWN: known = 1'b0;
        endcase

        // header length and optional field offsets
        qos_off = '0;
        ht_off  = '0;
        if (ftype_raw == TYPE_CTRL)
        begin
            hlen = ((sub_raw == SUB_CTRL_CTS) || (sub_raw == SUB_CTRL_ACK)) ?
                   HLEN_CTRL_SHORT : HLEN_CTRL_LONG;
            if (sub_raw == SUB_CTRL_WRAPPER)
            begin
                ht_off = OFF_CTRL_HT;
            end
        end
        else
        begin
            hlen = HLEN_BASE;
            if (ftype_raw == TYPE_DATA)
            begin
                if (to_ds && from_ds)
                begin
                    hlen = hlen + HLEN_ADDR4;
                end
                if (sub_raw[FC_QOS_SUB_BIT])
                begin
                    qos_off = hlen;
                    hlen    = hlen + HLEN_QOS;
                    if (order)
                    begin
                        ht_off = hlen;
                        hlen   = hlen + HLEN_HT;
                    end
                end
            end
            else if (order)
            begin
                ht_off = hlen;
                hlen   = hlen + HLEN_HT;
            end
        end

        priority if (!have_fc)
            status = ST_SHORT;
        else if (ver_bad)
            status = ST_VERSION;
        else if (ftype_raw == TYPE_UNKNOWN || !known)
            status = ST_LAYOUT;
        else if (ftype_raw != TYPE_DATA && (to_ds || from_ds))
            status = ST_FLAGS;
        else if (n_bytes >= hlen)
            status = ST_PARSED;
        else
            status = ST_SHORT;

        more_dur = type_ok && (n_bytes < N_DUR);
        dur_ok   = type_ok && (n_bytes >= N_DUR);
        emit     = last_byte || ((status != ST_SHORT) && !more_dur);

        // record list
        rec_en  = '0;
        rec_off = '0;
        rec_en[KIND_FC]       = have_fc;
        rec_en[KIND_DURATION] = dur_ok;
        rec_en[KIND_SUMMARY]  = 1'b1;
        rec_off[KIND_DURATION] = OFF_DURATION;
        rec_off[KIND_SEQUENCE] = OFF_SEQ;
        rec_off[KIND_QOS]      = qos_off;
        rec_off[KIND_HT]       = ht_off;
        if (status == ST_PARSED)
        begin
            rec_en[KIND_RECEIVER]  = 1'b1;
            rec_off[KIND_RECEIVER] = OFF_ADDR1;
            rec_en[KIND_QOS]       = qos_off != '0;
            rec_en[KIND_HT]        = ht_off != '0;
            if (ftype_raw == TYPE_CTRL)
            begin
                rec_en[KIND_DEST]  = 1'b1;
                rec_off[KIND_DEST] = OFF_ADDR1;
                if (sub_raw != SUB_CTRL_WRAPPER && hlen == HLEN_CTRL_LONG)
                begin
                    rec_en[KIND_TRANSMITTER]  = 1'b1;
                    rec_en[KIND_SOURCE]       = 1'b1;
                    rec_off[KIND_TRANSMITTER] = OFF_ADDR2;
                    rec_off[KIND_SOURCE]      = OFF_ADDR2;
                    if (sub_raw == SUB_CTRL_PS_POLL)
                    begin
                        rec_en[KIND_BSSID]  = 1'b1;
                        rec_off[KIND_BSSID] = OFF_ADDR1;
                    end
                    else if (sub_raw == SUB_CTRL_CF_END || sub_raw == SUB_CTRL_CF_END_A)
                    begin
                        rec_en[KIND_BSSID]  = 1'b1;
                        rec_off[KIND_BSSID] = OFF_ADDR2;
                    end
                end
            end
            else
            begin
                rec_en[KIND_TRANSMITTER]  = 1'b1;
                rec_en[KIND_DEST]         = 1'b1;
                rec_en[KIND_SOURCE]       = 1'b1;
                rec_en[KIND_SEQUENCE]     = 1'b1;
                rec_off[KIND_TRANSMITTER] = OFF_ADDR2;
                priority if (!to_ds && !from_ds)
                begin
                    rec_en[KIND_BSSID]  = 1'b1;
                    rec_off[KIND_DEST]  = OFF_ADDR1;
                    rec_off[KIND_SOURCE] = OFF_ADDR2;
                    rec_off[KIND_BSSID] = OFF_ADDR3;
                end
                else if (to_ds && from_ds)
                begin
                    rec_off[KIND_DEST]   = OFF_ADDR3;
                    rec_off[KIND_SOURCE] = OFF_ADDR4;
                end
                else if (to_ds)
                begin
                    rec_en[KIND_BSSID]   = 1'b1;
                    rec_off[KIND_DEST]   = OFF_ADDR3;
                    rec_off[KIND_SOURCE] = OFF_ADDR2;
                    rec_off[KIND_BSSID]  = OFF_ADDR1;
                end
                else
                begin
                    rec_en[KIND_BSSID]   = 1'b1;
                    rec_off[KIND_DEST]   = OFF_ADDR1;
                    rec_off[KIND_SOURCE] = OFF_ADDR3;
                    rec_off[KIND_BSSID]  = OFF_ADDR2;
                end
            end
        end
    end

    always_comb
    begin
        push_desc.bank    = wbank_reg;
        push_desc.rec_en  = rec_en;
        push_desc.rec_off = rec_off;
        push_desc.status  = status;
        push_desc.ftype   = type_ok ? ftype_raw : TYPE_UNKNOWN;
        push_desc.subtype = (have_fc && !ver_bad) ? sub_raw : '0;
        push_desc.hdr_len = ((status == ST_PARSED) || (status == ST_SHORT && have_fc)) ?
                            hlen : '0;
    end

    assign push_valid = accept && !discard_reg && emit;

    always_comb
    begin
        ram_wr.en   = accept && !discard_reg;
        ram_wr.addr = (wbank_reg ? RAM_AW'(STORE_DEPTH) : '0) + RAM_AW'(count_reg);
        ram_wr.data = byte_value;
    end

    always_comb
    begin
        count_next   = count_reg;
        discard_next = discard_reg;
        wbank_next   = wbank_reg;
        busy_next    = busy_reg;
        if (bank_done.valid)
        begin
            busy_next[bank_done.bank] = 1'b0;
        end
        if (accept)
        begin
            if (discard_reg)
            begin
                if (last_byte)
                begin
                    discard_next = 1'b0;
                    count_next   = '0;
                end
            end
            else if (emit)
            begin
                count_next           = '0;
                discard_next         = !last_byte;
                wbank_next           = !wbank_reg;
                busy_next[wbank_reg] = 1'b1;
            end
            else
            begin
                count_next = n_bytes;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            discard_reg <= 1'b0;
            wbank_reg   <= 1'b0;
            busy_reg    <= '0;
        end
        else
        begin
            count_reg   <= count_next;
            discard_reg <= discard_next;
            wbank_reg   <= wbank_next;
            busy_reg    <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !discard_reg)
        begin
            fc_reg <= fc_now;
        end
    end

    `WMHP_ASSERT_IMPLY(a_discard_empty, clk, rst_n, discard_reg, count_reg == '0)
    `WMHP_ASSERT_IMPLY(a_count_bound, clk, rst_n, 1'b1, count_reg < CNT_W'(STORE_DEPTH))

endmodule

// ===== rtl/wmhp_queue.sv =====
`timescale 1ns / 1ps
`include "wifi_mac_header_parser_unit_assert.svh"

module wmhp_queue
    import wmhp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  run_desc_t push_desc,
    input  logic      pop,
    output logic      head_valid,
    output run_desc_t head_desc
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

    run_desc_t         entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_QW-1:0] count_reg, count_next;

    assign head_valid = count_reg != '0;
    assign head_desc  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_QW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_QW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

    `WMHP_ASSERT_IMPLY(a_no_overflow, clk, rst_n, push, count_reg != CNT_QW'(QUEUE_DEPTH))

endmodule

// ===== rtl/wmhp_back.sv =====
`timescale 1ns / 1ps
`include "wifi_mac_header_parser_unit_assert.svh"

module wmhp_back
    import wmhp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  run_desc_t           q_desc,
    output logic                q_pop,
    output ram_rd_t             ram_rd,
    input  logic [BYTE_W-1:0]   ram_data,
    output bank_done_t          bank_done,
    output logic                record_valid,
    input  logic                record_stall,
    output logic [KIND_W-1:0]   record_kind,
    output logic [VALUE_W-1:0]  record_value,
    output logic [STATUS_W-1:0] parse_status,
    output logic [FTYPE_W-1:0]  frame_type,
    output logic [SUB_W-1:0]    frame_subtype,
    output logic [HLEN_W-1:0]   header_bytes,
    output logic                run_end
);

    // current run
    run_desc_t            job_reg, job_next;
    logic                 job_valid_reg, job_valid_next;
    logic [NUM_KINDS-1:0] rem_reg, rem_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;

    // read data stage
    logic                 p2_valid_reg, p2_valid_next;
    logic [KIND_W-1:0]    p2_kind_reg, p2_kind_next;
    logic [IDX_W-1:0]     p2_idx_reg, p2_idx_next;
    logic                 p2_last_reg, p2_last_next;
    logic [STATUS_W-1:0]  p2_status_reg, p2_status_next;
    logic [FTYPE_W-1:0]   p2_ftype_reg, p2_ftype_next;
    logic [SUB_W-1:0]     p2_sub_reg, p2_sub_next;
    logic [HLEN_W-1:0]    p2_hlen_reg, p2_hlen_next;
    logic [VALUE_W-1:0]   acc_reg, acc_next;

    // output register
    logic                 out_valid_reg, out_valid_next;
    logic [KIND_W-1:0]    out_kind_reg, out_kind_next;
    logic [VALUE_W-1:0]   out_value_reg, out_value_next;
    logic [STATUS_W-1:0]  out_status_reg, out_status_next;
    logic [FTYPE_W-1:0]   out_ftype_reg, out_ftype_next;
    logic [SUB_W-1:0]     out_sub_reg, out_sub_next;
    logic [HLEN_W-1:0]    out_hlen_reg, out_hlen_next;
    logic                 out_end_reg, out_end_next;

    logic                 advance, issue, issue_last, finish, load;
    logic [KIND_W-1:0]    cur_kind;
    logic [IDX_W-1:0]     cur_len;
    logic [BYTE_W-1:0]    byte_in;
    logic [VALUE_W-1:0]   acc_merge;
    logic                 p2_is_summary;

    // lowest pending kind goes next
    always_comb
    begin
        cur_kind = KIND_SUMMARY;
        for (int k = NUM_KINDS - 1; k >= 0; k--)
        begin
            if (rem_reg[k])
            begin
                cur_kind = KIND_W'(k);
            end
        end
    end

    assign cur_len    = kind_len(cur_kind);
    assign issue_last = idx_reg == (cur_len - IDX_W'(1));
    assign advance    = !out_valid_reg || !record_stall;
    assign issue      = advance && job_valid_reg;
    assign finish     = issue && issue_last && (cur_kind == KIND_SUMMARY);
    assign load       = !job_valid_reg || finish;
    assign q_pop      = load && q_valid;

    always_comb
    begin
        ram_rd.en   = issue;
        ram_rd.addr = (job_reg.bank ? RAM_AW'(STORE_DEPTH) : '0)
                    + RAM_AW'(job_reg.rec_off[cur_kind]) + RAM_AW'(idx_reg);
        bank_done.valid = finish;
        bank_done.bank  = job_reg.bank;
    end

    assign p2_is_summary = p2_kind_reg == KIND_SUMMARY;
    assign byte_in       = p2_is_summary ? '0 : ram_data;

    always_comb
    begin
        acc_merge = (p2_idx_reg == '0) ? '0 : acc_reg;
        acc_merge[{p2_idx_reg, 3'b000} +: BYTE_W] = byte_in;
    end

    always_comb
    begin
        job_next       = job_reg;
        job_valid_next = job_valid_reg;
        rem_next       = rem_reg;
        idx_next       = idx_reg;
        if (issue)
        begin
            if (issue_last)
            begin
                idx_next           = '0;
                rem_next[cur_kind] = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + IDX_W'(1);
            end
        end
        if (load)
        begin
            job_valid_next = q_valid;
            if (q_valid)
            begin
                job_next = q_desc;
                rem_next = q_desc.rec_en;
                idx_next = '0;
            end
        end
    end

    always_comb
    begin
        p2_valid_next  = p2_valid_reg;
        p2_kind_next   = p2_kind_reg;
        p2_idx_next    = p2_idx_reg;
        p2_last_next   = p2_last_reg;
        p2_status_next = p2_status_reg;
        p2_ftype_next  = p2_ftype_reg;
        p2_sub_next    = p2_sub_reg;
        p2_hlen_next   = p2_hlen_reg;
        acc_next       = acc_reg;
        if (advance)
        begin
            p2_valid_next  = issue;
            p2_kind_next   = cur_kind;
            p2_idx_next    = idx_reg;
            p2_last_next   = issue_last;
            p2_status_next = job_reg.status;
            p2_ftype_next  = job_reg.ftype;
            p2_sub_next    = job_reg.subtype;
            p2_hlen_next   = job_reg.hdr_len;
            if (p2_valid_reg)
            begin
                acc_next = acc_merge;
            end
        end
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_kind_next   = out_kind_reg;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        out_ftype_next  = out_ftype_reg;
        out_sub_next    = out_sub_reg;
        out_hlen_next   = out_hlen_reg;
        out_end_next    = out_end_reg;
        if (advance)
        begin
            out_valid_next = p2_valid_reg && p2_last_reg;
            if (p2_valid_reg && p2_last_reg)
            begin
                out_kind_next   = p2_kind_reg;
                out_value_next  = acc_merge;
                out_status_next = p2_is_summary ? p2_status_reg : '0;
                out_ftype_next  = p2_is_summary ? p2_ftype_reg : '0;
                out_sub_next    = p2_is_summary ? p2_sub_reg : '0;
                out_hlen_next   = p2_is_summary ? p2_hlen_reg : '0;
                out_end_next    = p2_is_summary;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            rem_reg       <= '0;
            idx_reg       <= '0;
            p2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            job_valid_reg <= job_valid_next;
            rem_reg       <= rem_next;
            idx_reg       <= idx_next;
            p2_valid_reg  <= p2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg        <= job_next;
        p2_kind_reg    <= p2_kind_next;
        p2_idx_reg     <= p2_idx_next;
        p2_last_reg    <= p2_last_next;
        p2_status_reg  <= p2_status_next;
        p2_ftype_reg   <= p2_ftype_next;
        p2_sub_reg     <= p2_sub_next;
        p2_hlen_reg    <= p2_hlen_next;
        acc_reg        <= acc_next;
        out_kind_reg   <= out_kind_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
        out_ftype_reg  <= out_ftype_next;
        out_sub_reg    <= out_sub_next;
        out_hlen_reg   <= out_hlen_next;
        out_end_reg    <= out_end_next;
    end

    assign record_valid  = out_valid_reg;
    assign record_kind   = out_kind_reg;
    assign record_value  = out_value_reg;
    assign parse_status  = out_status_reg;
    assign frame_type    = out_ftype_reg;
    assign frame_subtype = out_sub_reg;
    assign header_bytes  = out_hlen_reg;
    assign run_end       = out_end_reg;

    `WMHP_ASSERT_IMPLY(a_summary_pending, clk, rst_n, job_valid_reg, rem_reg[KIND_SUMMARY])
    `WMHP_ASSERT_NEXT(a_summary_follows, clk, rst_n, finish, p2_valid_reg && p2_is_summary)

endmodule

// ===== rtl/wifi_mac_header_parser_unit.sv =====
`timescale 1ns / 1ps

// channel   direction  handshake                  payload
// byte      in         byte_valid / byte_stall    byte_value[7:0], last_byte
// record    out        record_valid / record_stall record_kind[3:0], record_value[47:0],
//                                                 parse_status, frame_type,
//                                                 frame_subtype, header_bytes, run_end
//
// one byte is taken per cycle while byte_stall is low; the front writes it into one bank of the header ram
// each record is gathered byte by byte from its field (summary one byte), via the single ram read port
// bytes stall only when the next frame would fall into a bank not yet read out
// a stalled record holds the back, so bytes stall once both banks are waiting on it
// reset clears all control state; the header ram needs no clearing pass

module wifi_mac_header_parser_unit
    import wmhp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_stall,
    input  logic [BYTE_W-1:0]   byte_value,
    input  logic                last_byte,
    output logic                record_valid,
    input  logic                record_stall,
    output logic [KIND_W-1:0]   record_kind,
    output logic [VALUE_W-1:0]  record_value,
    output logic [STATUS_W-1:0] parse_status,
    output logic [FTYPE_W-1:0]  frame_type,
    output logic [SUB_W-1:0]    frame_subtype,
    output logic [HLEN_W-1:0]   header_bytes,
    output logic                run_end
);

    // front to queue
    logic        push_valid;
    run_desc_t   push_desc;

    // queue to back
    logic        q_valid;
    logic        q_pop;
    run_desc_t   q_desc;

    // header ram ports
    ram_wr_t     ram_wr;
    ram_rd_t     ram_rd;
    logic [BYTE_W-1:0] ram_data;

    // back hands a bank back to the front once its run is read out
    bank_done_t  bank_done;

    // front: stores header bytes, classifies the frame, decides when the run goes out
    wmhp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_value (byte_value),
        .last_byte  (last_byte),
        .bank_done  (bank_done),
        .ram_wr     (ram_wr),
        .push_valid (push_valid),
        .push_desc  (push_desc)
    );

    // short run queue between the two halves
    wmhp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push_valid),
        .push_desc  (push_desc),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_desc  (q_desc)
    );

    // double-banked header store
    wmhp_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (RAM_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr.en),
        .wr_addr (ram_wr.addr),
        .wr_data (ram_wr.data),
        .rd_en   (ram_rd.en),
        .rd_addr (ram_rd.addr),
        .rd_data (ram_data)
    );

    // back: walks the record list of each run, gathering field bytes
    wmhp_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_desc        (q_desc),
        .q_pop         (q_pop),
        .ram_rd        (ram_rd),
        .ram_data      (ram_data),
        .bank_done     (bank_done),
        .record_valid  (record_valid),
        .record_stall  (record_stall),
        .record_kind   (record_kind),
        .record_value  (record_value),
        .parse_status  (parse_status),
        .frame_type    (frame_type),
        .frame_subtype (frame_subtype),
        .header_bytes  (header_bytes),
        .run_end       (run_end)
    );

endmodule

// ===== verif/wifi_mac_header_parser_unit_tb.sv =====
`timescale 1ns / 1ps

module wifi_mac_header_parser_unit_tb;
    import wmhp_pkg::*;

    // clocking and run limits
    localparam int  HALF_PERIOD    = 2;
    localparam int  RESET_CYCLES   = 2;
    localparam int  RANDOM_BYTES   = 500;
    localparam int  SETTLE_CYCLES  = 64;     // time given for any stray record to show after the drain
    localparam int  WATCHDOG_LIMIT = 2000;   // cycles with no transaction on either channel

    // frame control layout
    localparam int  FC_TO_DS    = 8;
    localparam int  FC_FROM_DS  = 9;
    localparam int  FC_ORDER    = 15;
    localparam int  SUB_QOS_BIT = 3;

    // subtypes with a layout or validity of their own
    localparam logic [SUB_W-1:0] SUB_MGMT_RSVD_LO  = 4'd7;
    localparam logic [SUB_W-1:0] SUB_MGMT_RSVD_HI  = 4'd15;
    localparam logic [SUB_W-1:0] SUB_BEACON        = 4'd8;
    localparam logic [SUB_W-1:0] SUB_NDP_ANNOUNCE  = 4'd5;
    localparam logic [SUB_W-1:0] SUB_CTRL_WRAPPER  = 4'd7;
    localparam logic [SUB_W-1:0] SUB_PS_POLL       = 4'd10;
    localparam logic [SUB_W-1:0] SUB_CTS           = 4'd12;
    localparam logic [SUB_W-1:0] SUB_ACK           = 4'd13;
    localparam logic [SUB_W-1:0] SUB_CF_END        = 4'd14;
    localparam logic [SUB_W-1:0] SUB_CF_END_ACK    = 4'd15;
    localparam logic [SUB_W-1:0] SUB_DATA_RSVD     = 4'd13;

    // header byte offsets and lengths
    localparam int  OFF_ADDR1      = 4;
    localparam int  OFF_ADDR2      = 10;
    localparam int  OFF_WRAPPER_HT = 12;
    localparam int  OFF_ADDR3      = 16;
    localparam int  OFF_SEQ        = 22;
    localparam int  OFF_ADDR4      = 24;
    localparam int  HDR_CTRL_SHORT = 10;
    localparam int  HDR_CTRL       = 16;
    localparam int  HDR_BASE       = 24;
    localparam int  LEN_ADDR4      = 6;
    localparam int  LEN_QOS        = 2;
    localparam int  LEN_HT         = 4;

    typedef logic [BYTE_W-1:0] frame_bytes_t[$];

    // one output record as seen on the record channel
    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [VALUE_W-1:0]  value;
        logic [STATUS_W-1:0] status;
        logic [FTYPE_W-1:0]  ftype;
        logic [SUB_W-1:0]    subtype;
        logic [HLEN_W-1:0]   hlen;
        logic                fin;
    } header_record_t;

    // dut ports, all inputs known from time zero
    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                byte_valid   = 1'b0;
    logic [BYTE_W-1:0]   byte_value   = '0;
    logic                last_byte    = 1'b0;
    logic                record_stall = 1'b0;
    logic                byte_stall;
    logic                record_valid;
    logic [KIND_W-1:0]   record_kind;
    logic [VALUE_W-1:0]  record_value;
    logic [STATUS_W-1:0] parse_status;
    logic [FTYPE_W-1:0]  frame_type;
    logic [SUB_W-1:0]    frame_subtype;
    logic [HLEN_W-1:0]   header_bytes;
    logic                run_end;

    // parser shadow state
    logic [BYTE_W-1:0]   shadow_hdr [STORE_DEPTH];
    int                  shadow_count  = 0;
    bit                  shadow_drop   = 1'b0;
    header_record_t      expected_records[$];

    int                  error_count   = 0;
    int                  bytes_sent    = 0;
    int                  burst_left    = 0;
    int                  idle_cycles   = 0;
    int                  stall_mode    = 0;
    int                  stall_left    = 0;

    wifi_mac_header_parser_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_valid    (byte_valid),
        .byte_stall    (byte_stall),
        .byte_value    (byte_value),
        .last_byte     (last_byte),
        .record_valid  (record_valid),
        .record_stall  (record_stall),
        .record_kind   (record_kind),
        .record_value  (record_value),
        .parse_status  (parse_status),
        .frame_type    (frame_type),
        .frame_subtype (frame_subtype),
        .header_bytes  (header_bytes),
        .run_end       (run_end)
    );

    always #HALF_PERIOD clk = ~clk;

    // ------------------------------------------------------------------
    // header decoding shadow
    // ------------------------------------------------------------------

    // little-endian field from the buffered header, zero past the store
    function automatic logic [VALUE_W-1:0] header_field(input int off, input int len);
        logic [VALUE_W-1:0] acc;
        acc = '0;
        for (int i = 0; i < len; i++)
        begin
            if (off + i < STORE_DEPTH)
            begin
                acc |= VALUE_W'(shadow_hdr[off + i]) << (8 * i);
            end
        end
        return acc;
    endfunction

    function automatic bit subtype_defined(input logic [FTYPE_W-1:0] t,
                                           input logic [SUB_W-1:0] sub);
        if (t == TYPE_MGMT)
        begin
            return sub != SUB_MGMT_RSVD_LO && sub != SUB_MGMT_RSVD_HI;
        end
        if (t == TYPE_CTRL)
        begin
            return sub == SUB_NDP_ANNOUNCE || sub >= SUB_CTRL_WRAPPER;
        end
        return sub != SUB_DATA_RSVD;
    endfunction

    function automatic void queue_record(input logic [KIND_W-1:0] kind,
                                         input logic [VALUE_W-1:0] value,
                                         input logic [STATUS_W-1:0] status,
                                         input logic [FTYPE_W-1:0] ftype,
                                         input logic [SUB_W-1:0] sub,
                                         input int hlen,
                                         input logic fin);
        header_record_t rec;
        rec.kind    = kind;
        rec.value   = value;
        rec.status  = status;
        rec.ftype   = ftype;
        rec.subtype = sub;
        rec.hlen    = HLEN_W'(hlen);
        rec.fin     = fin;
        expected_records.push_back(rec);
    endfunction

    // advance the shadow by one accepted byte and queue the records it releases
    function automatic void decode_byte(input logic [BYTE_W-1:0] byte_in, input logic is_last);
        logic [15:0]          fc;
        logic [FTYPE_W-1:0]   t;
        logic [STATUS_W-1:0]  status;
        logic [FTYPE_W-1:0]   ftype;
        logic [SUB_W-1:0]     sub;
        logic [NUM_KINDS-1:0] fld_en;
        int                   fld_off [NUM_KINDS];
        int                   hl;
        int                   qos_off;
        int                   ht_off;
        bit                   fc_ok;
        bit                   dur_ok;
        bit                   more_dur;
        bit                   seq_ok;
        bit                   to_ds;
        bit                   from_ds;
        bit                   order;

        fc       = '0;
        t        = '0;
        status   = ST_SHORT;
        ftype    = TYPE_UNKNOWN;
        sub      = '0;
        fld_en   = '0;
        hl       = 0;
        qos_off  = 0;
        ht_off   = 0;
        fc_ok    = 1'b0;
        dur_ok   = 1'b0;
        more_dur = 1'b0;
        seq_ok   = 1'b0;
        to_ds    = 1'b0;
        from_ds  = 1'b0;
        order    = 1'b0;
        foreach (fld_off[i])
        begin
            fld_off[i] = 0;
        end

        // rest of a frame whose run is already out
        if (shadow_drop)
        begin
            if (is_last)
            begin
                shadow_drop  = 1'b0;
                shadow_count = 0;
            end
            return;
        end

        if (shadow_count < STORE_DEPTH)
        begin
            shadow_hdr[shadow_count] = byte_in;
            shadow_count++;
        end

        if (shadow_count >= 2)
        begin
            fc    = 16'(header_field(0, 2));
            fc_ok = 1'b1;
            if (fc[1:0] != 2'b00)
            begin
                status = ST_VERSION;
            end
            else
            begin
                t   = fc[3:2];
                sub = fc[7:4];
                if (t == TYPE_UNKNOWN)
                begin
                    status = ST_LAYOUT;
                end
                else
                begin
                    to_ds   = fc[FC_TO_DS];
                    from_ds = fc[FC_FROM_DS];
                    order   = fc[FC_ORDER];
                    ftype   = t;
                    if (shadow_count >= 4)
                    begin
                        dur_ok = 1'b1;
                    end
                    else
                    begin
                        more_dur = 1'b1;
                    end
                    if (!subtype_defined(t, sub))
                    begin
                        status = ST_LAYOUT;
                    end
                    else if (t != TYPE_DATA && (to_ds || from_ds))
                    begin
                        status = ST_FLAGS;
                    end
                    else
                    begin
                        if (t == TYPE_CTRL)
                        begin
                            hl = (sub == SUB_CTS || sub == SUB_ACK) ? HDR_CTRL_SHORT : HDR_CTRL;
                            if (sub == SUB_CTRL_WRAPPER)
                            begin
                                ht_off = OFF_WRAPPER_HT;
                            end
                        end
                        else
                        begin
                            hl = HDR_BASE;
                            if (t == TYPE_DATA)
                            begin
                                if (to_ds && from_ds)
                                begin
                                    hl += LEN_ADDR4;
                                end
                                if (sub[SUB_QOS_BIT])
                                begin
                                    qos_off = hl;
                                    hl += LEN_QOS;
                                    if (order)
                                    begin
                                        ht_off = hl;
                                        hl += LEN_HT;
                                    end
                                end
                            end
                            else if (order)
                            begin
                                ht_off = HDR_BASE;
                                hl += LEN_HT;
                            end
                        end

                        if (shadow_count >= hl)
                        begin
                            status = ST_PARSED;
                            fld_en[KIND_RECEIVER]  = 1'b1;
                            fld_off[KIND_RECEIVER] = OFF_ADDR1;
                            if (t == TYPE_CTRL)
                            begin
                                fld_en[KIND_DEST]  = 1'b1;
                                fld_off[KIND_DEST] = OFF_ADDR1;
                                if (sub != SUB_CTRL_WRAPPER && hl == HDR_CTRL)
                                begin
                                    fld_en[KIND_TRANSMITTER]  = 1'b1;
                                    fld_en[KIND_SOURCE]       = 1'b1;
                                    fld_off[KIND_TRANSMITTER] = OFF_ADDR2;
                                    fld_off[KIND_SOURCE]      = OFF_ADDR2;
                                    if (sub == SUB_PS_POLL)
                                    begin
                                        fld_en[KIND_BSSID]  = 1'b1;
                                        fld_off[KIND_BSSID] = OFF_ADDR1;
                                    end
                                    else if (sub == SUB_CF_END || sub == SUB_CF_END_ACK)
                                    begin
                                        fld_en[KIND_BSSID]  = 1'b1;
                                        fld_off[KIND_BSSID] = OFF_ADDR2;
                                    end
                                end
                            end
                            else
                            begin
                                fld_en[KIND_TRANSMITTER]  = 1'b1;
                                fld_en[KIND_DEST]         = 1'b1;
                                fld_en[KIND_SOURCE]       = 1'b1;
                                fld_off[KIND_TRANSMITTER] = OFF_ADDR2;
                                seq_ok = 1'b1;
                                // address roles follow the two ds flags
                                if (!to_ds && !from_ds)
                                begin
                                    fld_en[KIND_BSSID]  = 1'b1;
                                    fld_off[KIND_DEST]   = OFF_ADDR1;
                                    fld_off[KIND_SOURCE] = OFF_ADDR2;
                                    fld_off[KIND_BSSID]  = OFF_ADDR3;
                                end
                                else if (to_ds && from_ds)
                                begin
                                    fld_off[KIND_DEST]   = OFF_ADDR3;
                                    fld_off[KIND_SOURCE] = OFF_ADDR4;
                                end
                                else if (to_ds)
                                begin
                                    fld_en[KIND_BSSID]  = 1'b1;
                                    fld_off[KIND_DEST]   = OFF_ADDR3;
                                    fld_off[KIND_SOURCE] = OFF_ADDR2;
                                    fld_off[KIND_BSSID]  = OFF_ADDR1;
                                end
                                else
                                begin
                                    fld_en[KIND_BSSID]  = 1'b1;
                                    fld_off[KIND_DEST]   = OFF_ADDR1;
                                    fld_off[KIND_SOURCE] = OFF_ADDR3;
                                    fld_off[KIND_BSSID]  = OFF_ADDR2;
                                end
                            end
                        end
                    end
                end
            end
        end

        // the run goes out once the outcome is settled or the frame ends
        if (!(is_last || (status != ST_SHORT && !more_dur)))
        begin
            return;
        end

        if (fc_ok)
        begin
            queue_record(KIND_FC, VALUE_W'(fc), '0, '0, '0, 0, 1'b0);
        end
        if (dur_ok)
        begin
            queue_record(KIND_DURATION, header_field(2, 2), '0, '0, '0, 0, 1'b0);
        end
        if (status == ST_PARSED)
        begin
            for (int k = KIND_RECEIVER; k <= KIND_BSSID; k++)
            begin
                if (fld_en[k])
                begin
                    queue_record(KIND_W'(k), header_field(fld_off[k], 6), '0, '0, '0, 0, 1'b0);
                end
            end
            if (seq_ok)
            begin
                queue_record(KIND_SEQUENCE, header_field(OFF_SEQ, 2), '0, '0, '0, 0, 1'b0);
            end
            if (qos_off != 0)
            begin
                queue_record(KIND_QOS, header_field(qos_off, 2), '0, '0, '0, 0, 1'b0);
            end
            if (ht_off != 0)
            begin
                queue_record(KIND_HT, header_field(ht_off, 4), '0, '0, '0, 0, 1'b0);
            end
        end
        else if (status != ST_SHORT)
        begin
            hl = 0;
        end
        queue_record(KIND_SUMMARY, '0, status, ftype, sub, hl, 1'b1);

        shadow_count = 0;
        shadow_drop  = !is_last;
    endfunction

    // ------------------------------------------------------------------
    // byte channel driver
    // ------------------------------------------------------------------

    // one byte transaction; bursts of random length separated by random gaps
    task automatic send_byte(input logic [BYTE_W-1:0] data, input logic is_last);
        int gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 24);
            repeat (gap)
            begin
                @(negedge clk);
                byte_valid <= 1'b0;
            end
        end
        @(negedge clk);
        byte_valid <= 1'b1;
        byte_value <= data;
        last_byte  <= is_last;
        @(posedge clk);
        while (byte_stall)
        begin
            @(posedge clk);
        end
        decode_byte(data, is_last);
        burst_left--;
        bytes_sent++;
    endtask

    task automatic send_frame(input frame_bytes_t frame);
        foreach (frame[i])
        begin
            send_byte(frame[i], i == frame.size() - 1);
        end
    endtask

    // hold the sender off until every queued record has come back
    task automatic wait_records_drained();
        @(negedge clk);
        byte_valid <= 1'b0;
        while (expected_records.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // random frame: mostly well-formed headers with random contents,
    // the rest bad version, random control word, truncated or odd ds flags
    task automatic build_frame(output frame_bytes_t frame);
        logic [FTYPE_W-1:0] t;
        logic [SUB_W-1:0]   sub;
        logic [15:0]        fc;
        int                 pick;
        int                 hl;
        int                 len;

        pick = $urandom_range(0, 19);
        t    = (pick < 6) ? TYPE_MGMT : (pick < 11) ? TYPE_CTRL : TYPE_DATA;
        if (t == TYPE_CTRL)
        begin
            sub = 4'($urandom_range(0, 9));
            sub = (sub == 0) ? SUB_NDP_ANNOUNCE : sub + 4'd6;
        end
        else
        begin
            sub = 4'($urandom_range(0, 15));
            while (!subtype_defined(t, sub))
            begin
                sub = 4'($urandom_range(0, 15));
            end
        end
        fc[15:8] = 8'($urandom_range(0, 255));
        fc[7:0]  = {sub, t, 2'b00};
        if (t != TYPE_DATA)
        begin
            fc[FC_FROM_DS:FC_TO_DS] = 2'b00;
        end

        // nominal length, so that most frames reach a full parse
        if (t == TYPE_CTRL)
        begin
            hl = (sub == SUB_CTS || sub == SUB_ACK) ? HDR_CTRL_SHORT : HDR_CTRL;
        end
        else
        begin
            hl = HDR_BASE;
            if (t == TYPE_DATA && fc[FC_TO_DS] && fc[FC_FROM_DS])
            begin
                hl += LEN_ADDR4;
            end
            if (t == TYPE_DATA && sub[SUB_QOS_BIT])
            begin
                hl += LEN_QOS;
            end
            if (fc[FC_ORDER] && (t != TYPE_DATA || sub[SUB_QOS_BIT]))
            begin
                hl += LEN_HT;
            end
        end
        len = hl + $urandom_range(0, 3);

        if ($urandom_range(0, 9) >= 8)
        begin
            case ($urandom_range(0, 3))
                0: fc[1:0] = 2'($urandom_range(1, 3));
                1:
                begin
                    fc  = 16'($urandom);
                    len = $urandom_range(1, 40);
                end
                2: len = $urandom_range(1, hl - 1);
                default: fc[FC_FROM_DS:FC_TO_DS] = 2'($urandom_range(1, 3));
            endcase
        end

        frame = {};
        for (int i = 0; i < len; i++)
        begin
            frame.push_back(8'($urandom_range(0, 255)));
        end
        frame[0] = fc[7:0];
        if (len > 1)
        begin
            frame[1] = fc[15:8];
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // a frame of a single byte: unknown type, no fc record
    task automatic test_one_byte_frame();
        frame_bytes_t f;
        f = '{8'hFF};
        send_frame(f);
    endtask

    // version 3: run goes out at byte two, trailing byte dropped
    task automatic test_bad_version();
        frame_bytes_t f;
        f = '{8'h03, 8'hFF, 8'h00};
        send_frame(f);
    endtask

    // reserved type with last on the control word
    task automatic test_reserved_type();
        frame_bytes_t f;
        f = '{{SUB_CF_END_ACK, TYPE_UNKNOWN, 2'b00}, 8'h00};
        send_frame(f);
    endtask

    // reserved management subtype, frame ends before the duration is complete
    task automatic test_reserved_subtype();
        frame_bytes_t f;
        f = '{{SUB_MGMT_RSVD_LO, TYPE_MGMT, 2'b00}, 8'h00, 8'h12};
        send_frame(f);
    endtask

    // ds flag on a beacon: run at byte four, rest of frame dropped
    task automatic test_ds_flags_non_data();
        frame_bytes_t f;
        f = '{{SUB_BEACON, TYPE_MGMT, 2'b00}, 8'h01, 8'h34, 8'h12, 8'h55};
        send_frame(f);
    endtask

    // short control header closed by last on its final byte
    task automatic test_ack_frame();
        frame_bytes_t f;
        f = '{{SUB_ACK, TYPE_CTRL, 2'b00}, 8'h00, 8'hFF, 8'hFF,
              8'h00, 8'hFF, 8'h00, 8'hFF, 8'h5A, 8'hA5};
        send_frame(f);
    endtask

    // bulk of the run, with the odd full drain in between frames
    task automatic test_random_frames();
        frame_bytes_t f;
        int           target;
        target = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < target)
        begin
            build_frame(f);
            send_frame(f);
            if ($urandom_range(0, 5) == 0)
            begin
                wait_records_drained();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // record channel: stall pattern and checking
    // ------------------------------------------------------------------

    // phases of no stall, light or heavy random stall, and a strict toggle
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(8, 64);
        end
        stall_left--;
        case (stall_mode)
            0: record_stall <= 1'b0;
            1: record_stall <= ($urandom_range(0, 3) == 0);
            2: record_stall <= ($urandom_range(0, 3) != 0);
            default: record_stall <= ~record_stall;
        endcase
    end

    // every record transaction against the oldest outstanding expectation
    always @(posedge clk)
    begin : check_records
        header_record_t want;
        if (rst_n && record_valid && !record_stall)
        begin
            if (expected_records.size() == 0)
            begin
                $error("unexpected record: kind %0d value %h", record_kind, record_value);
                error_count++;
            end
            else
            begin
                want = expected_records.pop_front();
                if (record_kind !== want.kind)
                begin
                    $error("record_kind: expected %0d, got %0d", want.kind, record_kind);
                    error_count++;
                end
                if (record_value !== want.value)
                begin
                    $error("record_value: expected %h, got %h", want.value, record_value);
                    error_count++;
                end
                if (parse_status !== want.status)
                begin
                    $error("parse_status: expected %0d, got %0d", want.status, parse_status);
                    error_count++;
                end
                if (frame_type !== want.ftype)
                begin
                    $error("frame_type: expected %0d, got %0d", want.ftype, frame_type);
                    error_count++;
                end
                if (frame_subtype !== want.subtype)
                begin
                    $error("frame_subtype: expected %0d, got %0d", want.subtype, frame_subtype);
                    error_count++;
                end
                if (header_bytes !== want.hlen)
                begin
                    $error("header_bytes: expected %0d, got %0d", want.hlen, header_bytes);
                    error_count++;
                end
                if (run_end !== want.fin)
                begin
                    $error("run_end: expected %0d, got %0d", want.fin, run_end);
                    error_count++;
                end
            end
        end
    end

    // watchdog: too long without a transaction on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((byte_valid && !byte_stall) || (record_valid && !record_stall))
            begin
                idle_cycles <= 0;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_one_byte_frame();
        test_bad_version();
        test_reserved_type();
        test_reserved_subtype();
        test_ds_flags_non_data();
        test_ack_frame();
        wait_records_drained();
        test_random_frames();

        // let the last run drain, then give the block time to show any stray record
        wait_records_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (error_count == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== wifi_mac_header_parser_unit.f =====
+incdir+rtl
rtl/wmhp_pkg.sv
rtl/wmhp_ram.sv
rtl/wmhp_front.sv
rtl/wmhp_queue.sv
rtl/wmhp_back.sv
rtl/wifi_mac_header_parser_unit.sv
verif/wifi_mac_header_parser_unit_tb.sv
